// ===== rtl/uart_baud_divisor_search_top_defines.svh =====
// Assertion macros for the UART baud divisor search block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef UART_BAUD_DIVISOR_SEARCH_TOP_DEFINES_SVH
`define UART_BAUD_DIVISOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UBDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define UBDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ubds_pkg.sv =====
// Package for the UART baud divisor search block: field widths, register
// indexes, reset values and search defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ubds_pkg;

	localparam int CLK_W      = 30;
	localparam int RATE_W     = 24;
	localparam int SDIV_W     = 28;
	localparam int BDIV_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 30;

	localparam logic [CLK_W-1:0] REF_CLOCK_RESET = CLK_W'(100000000);

	localparam int DEF_MIN_BIT_DIVISOR       = 4;
	localparam int DEF_MAX_BIT_DIVISOR_LIMIT = 255;
	localparam int DEF_MAX_ERROR_PERCENT     = 3;

	// Percent scale of the error check.
	localparam int ERR_SCALE = 100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF_CLOCK    = 1'b0,
		REG_DIV_BY_EIGHT = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/uart_baud_divisor_search_top.sv =====
// Top level of the UART baud divisor search: sequencer, shared multiplier
// and shared restoring divider. Depends on ubds_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_search_top_defines.svh"

// Give a requested bit rate on bit_rate and pulse start while busy is low;
// the block searches every bit divisor b in [MIN_BIT_DIVISOR,
// MAX_BIT_DIVISOR_LIMIT) for the sample divisor s = clk / (rate * (b + 1)),
// keeps the first pair with the smallest error between the requested and the
// achieved rate, and reports it on sample_divisor / bit_divisor / rate_ok,
// marked by done, high for exactly one cycle. The receiver cannot stall:
// sample the word in the cycle done is high; it stays on the outputs until
// another result replaces it. The UART clock is the REG_REF_CLOCK value,
// divided by 8 when REG_DIV_BY_EIGHT is set. Requests above twice that
// clock, a zero rate or an error above MAX_ERROR_PERCENT give all zeros with
// rate_ok low. Each candidate takes a multiply and a restoring division for
// s, a second pair for the achieved rate unless s is zero, and an update
// step; final multiply and compare steps check the error. A request rejected
// up front is answered from idle with no search. The 30-step divider gives
// one quotient bit per cycle. Busy stays high for the whole search. Write
// the configuration registers only while the block is idle.
module uart_baud_divisor_search_top #(
	parameter int MIN_BIT_DIVISOR       = ubds_pkg::DEF_MIN_BIT_DIVISOR,
	parameter int MAX_BIT_DIVISOR_LIMIT = ubds_pkg::DEF_MAX_BIT_DIVISOR_LIMIT,
	parameter int MAX_ERROR_PERCENT     = ubds_pkg::DEF_MAX_ERROR_PERCENT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_write,
	input  wire logic [ubds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ubds_pkg::CFG_DATA_W-1:0] cfg_data,
	// request
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [ubds_pkg::RATE_W-1:0]     bit_rate,
	// result
	output logic                                 done,
	output logic [ubds_pkg::SDIV_W-1:0]          sample_divisor,
	output logic [ubds_pkg::BDIV_W-1:0]          bit_divisor,
	output logic                                 rate_ok
);
	import ubds_pkg::*;

	// Bit divisor counter holds up to MAX_BIT_DIVISOR_LIMIT (b + 1 at most).
	localparam int BCW = $clog2(MAX_BIT_DIVISOR_LIMIT + 1);
	localparam int PCW = $clog2(MAX_ERROR_PERCENT + 2);
	localparam int SCW = $clog2(ERR_SCALE + 1);
	localparam int MUL_BW_0 = (BCW > PCW) ? BCW : PCW;
	localparam int MUL_BW = (MUL_BW_0 > SCW) ? MUL_BW_0 : SCW;
	localparam int PROD_W = CLK_W + MUL_BW;
	localparam int CNT_W = $clog2(CLK_W);

	localparam logic [BCW-1:0] B_FIRST = BCW'(MIN_BIT_DIVISOR);
	localparam logic [BCW-1:0] B_LAST = BCW'(MAX_BIT_DIVISOR_LIMIT - 1);
	localparam logic [MUL_BW-1:0] PCT_LIMIT = MUL_BW'(MAX_ERROR_PERCENT + 1);
	localparam logic [MUL_BW-1:0] PCT_SCALE = MUL_BW'(ERR_SCALE);
	localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(CLK_W - 1);
	localparam bit NO_RANGE = (MIN_BIT_DIVISOR >= MAX_BIT_DIVISOR_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_S,
		ST_DIV_S,
		ST_MUL_A,
		ST_DIV_A,
		ST_UPDATE,
		ST_CHK_R,
		ST_CHK_E,
		ST_CHK_C
	} state_t;

	// configuration registers
	logic [CLK_W-1:0] ref_clock_q;
	logic             div_by_eight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q    <= REF_CLOCK_RESET;
			div_by_eight_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_REF_CLOCK:    ref_clock_q    <= cfg_data;
				REG_DIV_BY_EIGHT: div_by_eight_q <= cfg_data[0];
			endcase
		end
	end

	state_t              state_q;
	logic [CLK_W-1:0]    clk_q;        // UART clock, latched at start
	logic [RATE_W-1:0]   rate_q;
	logic [BCW-1:0]      b_q;
	logic [PROD_W-1:0]   mul_q;        // product register, also the divisor
	logic [PROD_W-1:0]   thr_q;        // rate * (percent + 1) for the final check
	logic [CLK_W-1:0]    q_q;          // dividend shifting out, quotient in
	logic [CLK_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CLK_W-1:0]    s_q;
	logic                found_q;
	logic [CLK_W-1:0]    best_err_q;
	logic [CLK_W-1:0]    best_s_q;
	logic [BCW-1:0]      best_b_q;
	logic                done_q;
	logic [SDIV_W-1:0]   sample_divisor_q;
	logic [BDIV_W-1:0]   bit_divisor_q;
	logic                rate_ok_q;

	// UART clock as configured now, for the up-front reject
	logic [CLK_W-1:0] clk_now;
	logic             early_fail;
	assign clk_now = div_by_eight_q ? (ref_clock_q >> 3) : ref_clock_q;
	assign early_fail = (bit_rate == '0) || (CLK_W'(bit_rate >> 1) > clk_now) || NO_RANGE;

	logic [BCW-1:0] b_plus1;
	logic           last_b;
	assign b_plus1 = b_q + 1'b1;
	assign last_b = (b_q == B_LAST);

	// shared multiplier operand select
	logic [CLK_W-1:0]  mul_a;
	logic [MUL_BW-1:0] mul_b;
	always_comb begin
		mul_a = CLK_W'(rate_q);
		mul_b = MUL_BW'(b_plus1);
		case (state_q)
			ST_MUL_A: begin
				mul_a = q_q;
			end
			ST_CHK_R: begin
				mul_b = PCT_LIMIT;
			end
			ST_CHK_E: begin
				mul_a = best_err_q;
				mul_b = PCT_SCALE;
			end
			default: ;
		endcase
	end

	// shared restoring divider step: dividend clk_q, divisor mul_q
	logic [CLK_W:0]   trial;
	logic             div_ge;
	logic [CLK_W-1:0] rem_next;
	assign trial = {rem_q, q_q[CLK_W-1]};
	assign div_ge = PROD_W'(trial) >= mul_q;
	assign rem_next = div_ge ? CLK_W'(trial - mul_q[CLK_W:0]) : trial[CLK_W-1:0];

	// error of the achieved rate (quotient of the second division)
	logic [CLK_W-1:0] rate_ext;
	logic [CLK_W-1:0] err;
	assign rate_ext = CLK_W'(rate_q);
	assign err = (rate_ext > q_q) ? (rate_ext - q_q) : (q_q - rate_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			rate_ok_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						clk_q   <= clk_now;
						rate_q  <= bit_rate;
						b_q     <= B_FIRST;
						found_q <= 1'b0;
						if (early_fail) begin
							// reject up front: zeros next cycle, stay idle
							done_q           <= 1'b1;
							sample_divisor_q <= '0;
							bit_divisor_q    <= '0;
							rate_ok_q        <= 1'b0;
						end else begin
							state_q <= ST_MUL_S;
						end
					end
				end
				ST_MUL_S: begin
					// rate * (b + 1), then divide the clock by it
					mul_q   <= PROD_W'(mul_a) * PROD_W'(mul_b);
					q_q     <= clk_q;
					rem_q   <= '0;
					cnt_q   <= DIV_LAST_STEP;
					state_q <= ST_DIV_S;
				end
				ST_DIV_S: begin
					q_q   <= {q_q[CLK_W-2:0], div_ge};
					rem_q <= rem_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					s_q <= q_q;
					if (q_q == '0) begin
						// skip a zero sample divisor
						if (last_b) begin
							state_q <= ST_CHK_R;
						end else begin
							b_q     <= b_plus1;
							state_q <= ST_MUL_S;
						end
					end else begin
						mul_q   <= PROD_W'(mul_a) * PROD_W'(mul_b);
						q_q     <= clk_q;
						rem_q   <= '0;
						cnt_q   <= DIV_LAST_STEP;
						state_q <= ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					q_q   <= {q_q[CLK_W-2:0], div_ge};
					rem_q <= rem_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// keep the first strictly smallest error
					if (!found_q || (err < best_err_q)) begin
						found_q    <= 1'b1;
						best_err_q <= err;
						best_s_q   <= s_q;
						best_b_q   <= b_q;
					end
					if (last_b) begin
						state_q <= ST_CHK_R;
					end else begin
						b_q     <= b_plus1;
						state_q <= ST_MUL_S;
					end
				end
				ST_CHK_R: begin
					mul_q   <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= ST_CHK_E;
				end
				ST_CHK_E: begin
					thr_q   <= mul_q;
					mul_q   <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= ST_CHK_C;
				end
				ST_CHK_C: begin
					// err*100/rate <= pct  is  err*100 < rate*(pct+1)
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (found_q && (mul_q < thr_q)) begin
						sample_divisor_q <= best_s_q[SDIV_W-1:0];
						bit_divisor_q    <= BDIV_W'(best_b_q);
						rate_ok_q        <= 1'b1;
					end else begin
						sample_divisor_q <= '0;
						bit_divisor_q    <= '0;
						rate_ok_q        <= 1'b0;
					end
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign sample_divisor = sample_divisor_q;
	assign bit_divisor    = bit_divisor_q;
	assign rate_ok        = rate_ok_q;

	`UBDS_ASSERT_NEXT(a_start_moves, start && !busy, busy || done,
		"accepted request neither started a search nor answered")
	`UBDS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still searching")
	`UBDS_ASSERT_NOW(a_fail_zero, done && !rate_ok,
		(sample_divisor == '0) && (bit_divisor == '0), "failed request with nonzero divisors")
	`UBDS_ASSERT_NOW(a_bdiv_range, done && rate_ok,
		(32'(bit_divisor) >= 32'(MIN_BIT_DIVISOR)) &&
		(32'(bit_divisor) < 32'(MAX_BIT_DIVISOR_LIMIT)),
		"bit divisor outside the search range")

endmodule

`default_nettype wire

// ===== dv/uart_baud_divisor_search_checker.sv =====
// Checker for the UART baud divisor search: mirrors the configuration writes,
// predicts the divisor word for each accepted rate and compares it with done.
// Depends on ubds_pkg.
`timescale 1ns / 1ps

module uart_baud_divisor_search_checker
	import ubds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire cfg_reg_t          cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [RATE_W-1:0] bit_rate,
	input  wire logic              done,
	input  wire logic [SDIV_W-1:0] sample_divisor,
	input  wire logic [BDIV_W-1:0] bit_divisor,
	input  wire logic              rate_ok,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [SDIV_W-1:0] sdiv;
		logic [BDIV_W-1:0] bdiv;
		logic              ok;
	} divisor_word_t;

	logic [CLK_W-1:0] ref_clock_q = REF_CLOCK_RESET;
	logic             div_by_eight_q = 1'b0;
	divisor_word_t    divisor_fifo[$];
	int               fail_count = 0;

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// Exhaustive search over the bit divisor range, 64-bit wide throughout.
	function automatic divisor_word_t best_divisors(input logic [RATE_W-1:0] rate);
		longint unsigned uart_clk, r, span, s, achieved, err, best_err, best_s;
		int              b, best_b;
		bit              found;
		divisor_word_t   w;
		w        = '0;
		found    = 1'b0;
		best_err = 0;
		best_s   = 0;
		best_b   = 0;
		r        = rate;
		uart_clk = div_by_eight_q ? longint'(ref_clock_q >> 3) : longint'(ref_clock_q);
		if (r == 0 || (r >> 1) > uart_clk)
			return w;
		for (b = DEF_MIN_BIT_DIVISOR; b < DEF_MAX_BIT_DIVISOR_LIMIT; b++) begin
			span = longint'(b + 1);
			s = uart_clk / (r * span);
			if (s != 0) begin
				achieved = uart_clk / (s * span);
				err = (r > achieved) ? r - achieved : achieved - r;
				if (!found || err < best_err) begin
					found    = 1'b1;
					best_err = err;
					best_s   = s;
					best_b   = b;
				end
			end
		end
		if (found && (best_err * ERR_SCALE) / r <= DEF_MAX_ERROR_PERCENT) begin
			w.sdiv = best_s[SDIV_W-1:0];
			w.bdiv = best_b[BDIV_W-1:0];
			w.ok   = 1'b1;
		end
		return w;
	endfunction

	task automatic report(input string what, input divisor_word_t want,
			input divisor_word_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s: expected sdiv=%0d bdiv=%0d ok=%0b, got sdiv=%0d bdiv=%0d ok=%0b",
				$realtime, what, want.sdiv, want.bdiv, want.ok, got.sdiv, got.bdiv, got.ok);
	endtask

	always @(posedge clk or negedge arst_n) begin
		divisor_word_t want, got;
		if (!arst_n) begin
			ref_clock_q    = REF_CLOCK_RESET;
			div_by_eight_q = 1'b0;
			divisor_fifo.delete();
			pending <= 0;
		end else begin
			if (done) begin
				got.sdiv = sample_divisor;
				got.bdiv = bit_divisor;
				got.ok   = rate_ok;
				if (divisor_fifo.size() == 0) begin
					report("unexpected word", '0, got);
				end else begin
					want = divisor_fifo.pop_front();
					if (got.sdiv !== want.sdiv || got.bdiv !== want.bdiv
							|| got.ok !== want.ok)
						report("word mismatch", want, got);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_REF_CLOCK:    ref_clock_q = cfg_data[CLK_W-1:0];
					REG_DIV_BY_EIGHT: div_by_eight_q = cfg_data[0];
					default:          ;
				endcase
			end
			if (start && !busy)
				divisor_fifo.push_back(best_divisors(bit_rate));
			pending    <= divisor_fifo.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ===== dv/uart_baud_divisor_search_top_tb.sv =====
// Testbench top for the UART baud divisor search: drives configuration and
// rate requests, gives the verdict. Depends on ubds_pkg, the block and the checker.
`timescale 1ns / 1ps

module uart_baud_divisor_search_top_tb;
	import ubds_pkg::*;

	// Watchdog limit: the longest quiet stretch allowed with no word.
	localparam int WATCHDOG_LIMIT = 200000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	cfg_reg_t              cfg_index = REG_REF_CLOCK;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  start     = 1'b0;
	logic [RATE_W-1:0]     bit_rate  = '0;
	logic                  busy;
	logic                  done;
	logic [SDIV_W-1:0]     sample_divisor;
	logic [BDIV_W-1:0]     bit_divisor;
	logic                  rate_ok;

	int mismatches;
	int pending;
	int idle_pct     = 0;
	int quiet_cycles = 0;

	// Shadow of the configuration, used only to aim the random rates.
	logic [CLK_W-1:0] cur_ref  = REF_CLOCK_RESET;
	logic             cur_div8 = 1'b0;

	always #4 clk = ~clk;

	uart_baud_divisor_search_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.bit_rate       (bit_rate),
		.done           (done),
		.sample_divisor (sample_divisor),
		.bit_divisor    (bit_divisor),
		.rate_ok        (rate_ok)
	);

	uart_baud_divisor_search_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.bit_rate       (bit_rate),
		.done           (done),
		.sample_divisor (sample_divisor),
		.bit_divisor    (bit_divisor),
		.rate_ok        (rate_ok),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// Watchdog: restart the count on every accepted request or returned word.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Write one register; hold the strobe for a single cycle and drop it again
	// before returning, so back-to-back writes never touch cfg_write twice in a step.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_REF_CLOCK)
			cur_ref = value[CLK_W-1:0];
		else
			cur_div8 = value[0];
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Drop start and wait until every predicted word has come back and the
	// block reports idle. The first edge lets the checker's count catch up.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	// Present one rate and hold it until the block takes it. start is lowered
	// only when an idle gap is inserted, so it never toggles within a step.
	task automatic send_rate(input logic [RATE_W-1:0] rate);
		int gap;
		if ($urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 24);
			// Half the gaps start once the search is over, so they also land
			// in the window where the block sits idle.
			if ($urandom_range(0, 1))
				do @(posedge clk); while (busy);
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		bit_rate <= rate;
		do @(posedge clk); while (busy);
	endtask

	// Mostly rates the search can meet, plus raw noise and the too-high edge.
	function automatic logic [RATE_W-1:0] pick_rate();
		longint unsigned uart_clk, r;
		uart_clk = cur_div8 ? longint'(cur_ref >> 3) : longint'(cur_ref);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				case ($urandom_range(0, 11))
					0:       r = 300;
					1:       r = 1200;
					2:       r = 2400;
					3:       r = 4800;
					4:       r = 9600;
					5:       r = 19200;
					6:       r = 38400;
					7:       r = 57600;
					8:       r = 115200;
					9:       r = 230400;
					10:      r = 921600;
					default: r = 3000000;
				endcase
			end
			3, 4, 5: begin
				// Back off from an exact divisor pair, with a little skew.
				if (uart_clk >= 5)
					r = uart_clk / (longint'($urandom_range(1, 64))
						* longint'($urandom_range(5, 255)));
				else
					r = $urandom_range(1, 3);
				r = r + $urandom_range(0, 3);
			end
			6, 7:    r = $urandom & 32'h00FF_FFFF;
			8:       r = $urandom_range(1, 4096);
			default: r = uart_clk * 2 + $urandom_range(0, 2);
		endcase
		return r[RATE_W-1:0];
	endfunction

	initial begin
		int               seg;
		logic [CLK_W-1:0] new_ref;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset configuration, zero rate and the rate field extremes.
		send_rate('0);
		send_rate(24'd1);
		send_rate(24'hFF_FFFF);
		send_rate(24'h55_5555);
		send_rate(24'hAA_AAAA);
		send_rate(24'd115200);
		send_rate(24'd9600);

		// Tiny clock: one rate just above twice the clock, one with every
		// candidate skipped, one that meets the search exactly.
		settle();
		write_reg(REG_REF_CLOCK, CFG_DATA_W'(1000));
		send_rate(24'd2002);
		send_rate(24'd2001);
		send_rate(24'd200);

		// UART clock of zero after the divide by eight.
		settle();
		write_reg(REG_REF_CLOCK, CFG_DATA_W'(5));
		write_reg(REG_DIV_BY_EIGHT, CFG_DATA_W'(1));
		send_rate(24'd1);
		send_rate(24'd2);

		// Largest reference clock, divided down.
		settle();
		write_reg(REG_REF_CLOCK, '1);
		send_rate(24'd115200);
		send_rate(24'd1);
		send_rate(24'hFF_FFFF);

		// Reference clock of zero, undivided.
		settle();
		write_reg(REG_REF_CLOCK, '0);
		write_reg(REG_DIV_BY_EIGHT, '0);
		send_rate(24'd1);
		send_rate(24'd3);

		// Classic UART crystal: clean matches and a rate with no candidate.
		settle();
		write_reg(REG_REF_CLOCK, CFG_DATA_W'(14745600));
		send_rate(24'd115200);
		send_rate(24'd3686400);
		send_rate(24'd921600);

		// Random: nine settings, a drain before each, sender idling 23% then
		// 54% then never.
		for (seg = 0; seg < 9; seg++) begin
			settle();
			idle_pct = (seg < 3) ? 23 : (seg < 6) ? 54 : 0;
			case ($urandom_range(0, 3))
				0: begin
					case ($urandom_range(0, 5))
						0:       new_ref = 100000000;
						1:       new_ref = 50000000;
						2:       new_ref = 33333333;
						3:       new_ref = 14745600;
						4:       new_ref = 1843200;
						default: new_ref = 125000000;
					endcase
				end
				1:       new_ref = CLK_W'($urandom_range(1, 30'h3FFF_FFFF));
				2:       new_ref = CLK_W'($urandom_range(1, 2000000));
				default: new_ref = CLK_W'($urandom);
			endcase
			write_reg(REG_REF_CLOCK, new_ref);
			write_reg(REG_DIV_BY_EIGHT, CFG_DATA_W'($urandom_range(0, 1)));
			repeat (9) send_rate(pick_rate());
		end

		// Drain, then give any stray done a chance to show up.
		settle();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
